@@ rtl/core/tsbk_pkg.sv @@
// Shared types, opcodes and frequency helper for the control block grant decoder.
package tsbk_pkg;

    localparam logic [5:0] OP_GRANT        = 6'h00;
    localparam logic [5:0] OP_GRANT_UPDATE = 6'h02;
    localparam logic [5:0] OP_EXPLICIT     = 6'h03;
    localparam logic [5:0] OP_ID_UPDATE    = 6'h3d;
    localparam logic [5:0] OP_ID_UPDATE_VU = 6'h34;

    localparam logic [7:0] VENDOR_ALT      = 8'h90;
    localparam logic [3:0] BLOCK_MIN_BYTES = 4'd10;
    localparam logic [16:0] SPACING_STEP_HZ = 17'd125;

    typedef enum logic [2:0] {
        KIND_UNKNOWN      = 3'd0,
        KIND_ID_UPDATE    = 3'd1,
        KIND_GRANT        = 3'd2,
        KIND_GRANT_UPDATE = 3'd3,
        KIND_EXPLICIT     = 3'd4
    } t_kind;

    typedef struct packed {
        logic        en;
        logic [3:0]  id;
        logic [31:0] base_units;
        logic [9:0]  spacing_units;
    } t_plan_wr;

    typedef struct packed {
        logic        hit;
        logic [31:0] base_units;
        logic [16:0] spacing_hz;
    } t_plan_rd;

    typedef struct packed {
        t_kind       kind;
        logic [5:0]  op_code;
        logic [7:0]  vendor_id;
        logic [15:0] chan_word;
        logic [15:0] chan_word_b;
        logic [15:0] talk_group;
        logic [23:0] source_unit;
        logic        is_encrypted;
        logic        enc_known;
        logic [34:0] freq_hz;
        logic [34:0] freq_b_hz;
        logic        last;
    } t_event;

    // base is in 5 Hz units: base * 5 = (base << 2) + base
    function automatic logic [34:0] plan_freq(input t_plan_rd rd, input logic [11:0] num);
        logic [34:0] base_hz;
        logic [28:0] step_hz;
        base_hz = {1'b0, rd.base_units, 2'b00} + {3'b000, rd.base_units};
        step_hz = 29'(num) * 29'(rd.spacing_hz);
        plan_freq = rd.hit ? (base_hz + 35'(step_hz)) : 35'd0;
    endfunction

endpackage

@@ rtl/core/tsbk_plan_table.sv @@
// Band plan table: per-entry valid flags, base and spacing memory, two registered read ports.
module tsbk_plan_table #(
    parameter int PLAN_ENTRIES = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_rd_en,
    input  logic [3:0]         i_rd_id_a,
    input  logic [3:0]         i_rd_id_b,
    input  tsbk_pkg::t_plan_wr i_wr,
    output tsbk_pkg::t_plan_rd o_rd_a,
    output tsbk_pkg::t_plan_rd o_rd_b
);

    localparam int AW = (PLAN_ENTRIES > 1) ? $clog2(PLAN_ENTRIES) : 1;

    logic [PLAN_ENTRIES-1:0] r_valid;
    logic [31:0]             r_base [PLAN_ENTRIES];
    logic [16:0]             r_spacing [PLAN_ENTRIES];

    logic          wr_ok, in_a, in_b;
    logic [AW-1:0] wr_addr, addr_a, addr_b;

    always_comb begin
        wr_ok   = i_wr.en && ({1'b0, i_wr.id} < 5'(PLAN_ENTRIES));
        in_a    = {1'b0, i_rd_id_a} < 5'(PLAN_ENTRIES);
        in_b    = {1'b0, i_rd_id_b} < 5'(PLAN_ENTRIES);
        wr_addr = wr_ok ? i_wr.id[AW-1:0] : '0;
        addr_a  = in_a ? i_rd_id_a[AW-1:0] : '0;
        addr_b  = in_b ? i_rd_id_b[AW-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (wr_ok) begin
            r_valid[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_base[wr_addr]    <= i_wr.base_units;
            r_spacing[wr_addr] <= 17'(i_wr.spacing_units) * tsbk_pkg::SPACING_STEP_HZ;
        end
    end

    // read before write: an item never looks up the entry it writes itself
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_a.hit        <= in_a && r_valid[addr_a];
            o_rd_a.base_units <= r_base[addr_a];
            o_rd_a.spacing_hz <= r_spacing[addr_a];
            o_rd_b.hit        <= in_b && r_valid[addr_b];
            o_rd_b.base_units <= r_base[addr_b];
            o_rd_b.spacing_hz <= r_spacing[addr_b];
        end
    end

endmodule

@@ rtl/core/tsbk_event_build.sv @@
// Field decode and frequency arithmetic: builds up to two events from one staged block.
module tsbk_event_build (
    input  logic [63:0]        i_head,
    input  logic [15:0]        i_tail,
    input  tsbk_pkg::t_plan_rd i_rd_a,
    input  tsbk_pkg::t_plan_rd i_rd_b,
    output tsbk_pkg::t_event   o_ev_a,
    output tsbk_pkg::t_event   o_ev_b,
    output logic               o_two
);

    logic [79:0] blk;
    logic [5:0]  op;
    logic [7:0]  vendor;
    logic [34:0] freq_a, freq_b;

    always_comb begin
        blk    = {i_head, i_tail};
        op     = blk[77:72];
        vendor = blk[71:64];
        o_ev_a = '0;
        o_two  = 1'b0;
        o_ev_a.op_code   = op;
        o_ev_a.vendor_id = vendor;

        unique case (op)
            tsbk_pkg::OP_ID_UPDATE, tsbk_pkg::OP_ID_UPDATE_VU: begin
                o_ev_a.kind      = tsbk_pkg::KIND_ID_UPDATE;
                o_ev_a.chan_word = {blk[63:60], 12'h000};
            end
            tsbk_pkg::OP_GRANT: begin
                o_ev_a.kind         = tsbk_pkg::KIND_GRANT;
                o_ev_a.enc_known    = 1'b1;
                o_ev_a.is_encrypted = blk[62];
                o_ev_a.chan_word    = blk[55:40];
                o_ev_a.talk_group   = blk[39:24];
                o_ev_a.source_unit  = blk[23:0];
            end
            tsbk_pkg::OP_EXPLICIT: begin
                o_ev_a.kind         = tsbk_pkg::KIND_EXPLICIT;
                o_ev_a.enc_known    = 1'b1;
                o_ev_a.is_encrypted = blk[62];
                o_ev_a.chan_word    = blk[47:32];
                o_ev_a.chan_word_b  = blk[31:16];
                o_ev_a.talk_group   = blk[15:0];
            end
            tsbk_pkg::OP_GRANT_UPDATE: begin
                o_ev_a.kind = tsbk_pkg::KIND_GRANT_UPDATE;
                if (vendor == tsbk_pkg::VENDOR_ALT) begin
                    o_ev_a.chan_word   = blk[55:40];
                    o_ev_a.talk_group  = blk[39:24];
                    o_ev_a.source_unit = blk[23:0];
                end else begin
                    o_ev_a.chan_word  = blk[63:48];
                    o_ev_a.talk_group = blk[47:32];
                    o_two = (blk[31:16] != 16'h0000) || (blk[15:0] != 16'h0000);
                end
            end
            default: begin
                o_ev_a.kind = tsbk_pkg::KIND_UNKNOWN;
            end
        endcase

        // plan id lane b always sits in bits 28..31, number in the next 12 bits
        freq_a = tsbk_pkg::plan_freq(i_rd_a, o_ev_a.chan_word[11:0]);
        freq_b = tsbk_pkg::plan_freq(i_rd_b, blk[27:16]);

        if (o_ev_a.kind == tsbk_pkg::KIND_GRANT || o_ev_a.kind == tsbk_pkg::KIND_EXPLICIT ||
            o_ev_a.kind == tsbk_pkg::KIND_GRANT_UPDATE) begin
            o_ev_a.freq_hz = freq_a;
        end
        if (o_ev_a.kind == tsbk_pkg::KIND_EXPLICIT) begin
            o_ev_a.freq_b_hz = freq_b;
        end
        o_ev_a.last = !o_two;

        o_ev_b            = o_ev_a;
        o_ev_b.chan_word  = blk[31:16];
        o_ev_b.talk_group = blk[15:0];
        o_ev_b.freq_hz    = freq_b;
        o_ev_b.last       = 1'b1;
    end

endmodule

@@ rtl/core/tsbk_grant_decoder_core.sv @@
// Top level: input stage, band plan lookup, event build and output register.
// Path: a block is held in the input stage registers, then in the output register.
// Throughput: one block per cycle while the output is not stalled; a grant update
// with a second event holds the output register for both events, one per transfer.
// Reset: synchronous, active low; clears pipeline valid flags and plan valid bits at once.
// Blocks shorter than ten bytes are taken and dropped with no event.
module tsbk_grant_decoder_core #(
    parameter int PLAN_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [3:0]  i_byte_count,
    input  logic [63:0] i_head_bits,
    input  logic [15:0] i_tail_bits,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic [5:0]  o_op_code,
    output logic [7:0]  o_vendor_id,
    output logic [15:0] o_chan_word,
    output logic [15:0] o_chan_word_b,
    output logic [15:0] o_talk_group,
    output logic [23:0] o_source_unit,
    output logic        o_is_encrypted,
    output logic        o_enc_known,
    output logic [34:0] o_freq_hz,
    output logic [34:0] o_freq_b_hz,
    output logic        o_last
);

    logic        r_s1_valid;
    logic [63:0] r_head;
    logic [15:0] r_tail;

    logic             r_out_valid, r_out_two, r_sel;
    tsbk_pkg::t_event r_out_a, r_out_b;

    tsbk_pkg::t_plan_wr plan_wr;
    tsbk_pkg::t_plan_rd rd_a, rd_b;
    tsbk_pkg::t_event   ev_a, ev_b, cur;
    logic               two;

    logic       in_acc, long_blk, out_acc, out_free, s1_adv;
    logic [5:0] in_op;
    logic [7:0] in_vendor;
    logic [3:0] id_a;

    always_comb begin
        out_acc    = r_out_valid && !i_out_stall;
        out_free   = !r_out_valid || (out_acc && (r_sel || !r_out_two));
        s1_adv     = r_s1_valid && out_free;
        o_in_stall = r_s1_valid && !out_free;
        in_acc     = i_in_valid && !o_in_stall;
        long_blk   = i_byte_count >= tsbk_pkg::BLOCK_MIN_BYTES;
        in_op      = i_head_bits[61:56];
        in_vendor  = i_head_bits[55:48];

        // pick the plan id of the first channel field for this opcode
        priority if (in_op == tsbk_pkg::OP_GRANT ||
                     (in_op == tsbk_pkg::OP_GRANT_UPDATE && in_vendor == tsbk_pkg::VENDOR_ALT)) begin
            id_a = i_head_bits[39:36];
        end else if (in_op == tsbk_pkg::OP_EXPLICIT) begin
            id_a = i_head_bits[31:28];
        end else begin
            id_a = i_head_bits[47:44];
        end

        plan_wr.id            = i_head_bits[47:44];
        plan_wr.spacing_units = i_head_bits[25:16];
        plan_wr.base_units    = {i_head_bits[15:0], i_tail_bits};
        plan_wr.en = in_acc && long_blk &&
                     (in_op == tsbk_pkg::OP_ID_UPDATE || in_op == tsbk_pkg::OP_ID_UPDATE_VU) &&
                     (plan_wr.base_units != 32'd0) && (plan_wr.spacing_units != 10'd0);
    end

    tsbk_plan_table #(
        .PLAN_ENTRIES(PLAN_ENTRIES)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_acc),
        .i_rd_id_a (id_a),
        .i_rd_id_b (i_head_bits[15:12]),
        .i_wr      (plan_wr),
        .o_rd_a    (rd_a),
        .o_rd_b    (rd_b)
    );

    tsbk_event_build u_build (
        .i_head (r_head),
        .i_tail (r_tail),
        .i_rd_a (rd_a),
        .i_rd_b (rd_b),
        .o_ev_a (ev_a),
        .o_ev_b (ev_b),
        .o_two  (two)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_acc) begin
            r_s1_valid <= long_blk;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_head <= i_head_bits;
            r_tail <= i_tail_bits;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_out_two   <= 1'b0;
            r_sel       <= 1'b0;
        end else if (s1_adv) begin
            r_out_valid <= 1'b1;
            r_out_two   <= two;
            r_sel       <= 1'b0;
        end else if (out_acc) begin
            // advance to the second event, or drop the pair once both are out
            if (r_out_two && !r_sel) begin
                r_sel <= 1'b1;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv) begin
            r_out_a <= ev_a;
            r_out_b <= ev_b;
        end
    end

    always_comb begin
        cur            = r_sel ? r_out_b : r_out_a;
        o_out_valid    = r_out_valid;
        o_event_kind   = cur.kind;
        o_op_code      = cur.op_code;
        o_vendor_id    = cur.vendor_id;
        o_chan_word    = cur.chan_word;
        o_chan_word_b  = cur.chan_word_b;
        o_talk_group   = cur.talk_group;
        o_source_unit  = cur.source_unit;
        o_is_encrypted = cur.is_encrypted;
        o_enc_known    = cur.enc_known;
        o_freq_hz      = cur.freq_hz;
        o_freq_b_hz    = cur.freq_b_hz;
        o_last         = cur.last;
    end

endmodule

@@ rtl/core/tsbk_checker.sv @@
// Port-level checker for the grant decoder and its bind to the top level.
module tsbk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [3:0]  i_byte_count,
    input logic [63:0] i_head_bits,
    input logic [15:0] i_tail_bits,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_event_kind,
    input logic [5:0]  o_op_code,
    input logic [7:0]  o_vendor_id,
    input logic [15:0] o_chan_word,
    input logic [15:0] o_chan_word_b,
    input logic [15:0] o_talk_group,
    input logic [23:0] o_source_unit,
    input logic        o_is_encrypted,
    input logic        o_enc_known,
    input logic [34:0] o_freq_hz,
    input logic [34:0] o_freq_b_hz,
    input logic        o_last
);

    // a stalled event holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_chan_word) && $stable(o_freq_hz) && $stable(o_last))
        else $error("stalled output event changed");

    // the second event of a grant update follows at once, same opcode and vendor
    a_second_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_last && !i_out_stall |=>
            o_out_valid && o_last &&
            (o_event_kind == tsbk_pkg::KIND_GRANT_UPDATE) &&
            (o_op_code == $past(o_op_code)) && (o_vendor_id == $past(o_vendor_id)))
        else $error("second event missing after non-final transfer");

    // input backpressure only comes from a full output register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output valid right after reset");

endmodule

bind tsbk_grant_decoder_core tsbk_checker u_tsbk_checker (.*);
